FILE: sv/qcpc_pkg.sv
package qcpc_pkg;

   localparam int unsigned CHAN_W  = 16;
   localparam int unsigned KEY_W   = 3 * CHAN_W;
   localparam int unsigned QUAL_W  = 5;
   localparam int unsigned LIMIT_W = 9;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned OUTC_W  = 2;

   localparam logic [QUAL_W-1:0]  QUALITY_RESET = 5'd6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 9'd256;

   // Color that always maps to slot 0 without a search.
   localparam logic [CHAN_W-1:0] FIXED_RED   = 16'h0000;
   localparam logic [CHAN_W-1:0] FIXED_GREEN = 16'h0000;
   localparam logic [CHAN_W-1:0] FIXED_BLUE  = 16'hff00;

   localparam logic [OUTC_W-1:0] OUTCOME_HIT  = 2'd0;
   localparam logic [OUTC_W-1:0] OUTCOME_NEW  = 2'd1;
   localparam logic [OUTC_W-1:0] OUTCOME_FULL = 2'd2;

   localparam logic CSR_QUALITY = 1'b0;
   localparam logic CSR_LIMIT   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic start;   // take the request and clear the scan
      logic scan;    // issue one key read and compare
      logic latch;   // capture the search result
      logic commit;  // allocate if needed and load the output register
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic out_free;
   } status_type;

   // Keeps the top quality bits of a channel; quality 0 acts as 1, above 16 as 16.
   function automatic logic [CHAN_W-1:0] channel_mask(input logic [QUAL_W-1:0] q);
      logic [QUAL_W-1:0] qc;
      logic [3:0]        sh;
      if (q == 5'd0) begin
         qc = 5'd1;
      end else if (q > 5'd16) begin
         qc = 5'd16;
      end else begin
         qc = q;
      end
      sh = 4'(5'd16 - qc);
      return 16'hffff << sh;
   endfunction

endpackage

FILE: sv/qcpc_ctrl.sv
module qcpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  qcpc_pkg::status_type   status,
   output qcpc_pkg::cmd_type      cmd
);

   qcpc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         qcpc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = qcpc_pkg::ST_SCAN;
            end
         end
         qcpc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.miss) begin
               cmd.latch = 1'b1;
               state_in  = qcpc_pkg::ST_DONE;
            end
         end
         qcpc_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = qcpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qcpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qcpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/qcpc_datapath.sv
module qcpc_datapath #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [qcpc_pkg::KEY_W-1:0]          req_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_addr,
   input  logic [qcpc_pkg::LIMIT_W-1:0]        csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [qcpc_pkg::SLOT_W-1:0]         rsp_tdata,
   output logic [qcpc_pkg::OUTC_W-1:0]         rsp_tuser,
   input  qcpc_pkg::cmd_type                   cmd,
   output qcpc_pkg::status_type                status
);

   localparam int unsigned AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int unsigned CW = $clog2(PALETTE_SIZE + 1);
   localparam int unsigned LW = (CW > qcpc_pkg::LIMIT_W) ? CW : qcpc_pkg::LIMIT_W;

   logic [qcpc_pkg::KEY_W-1:0] key_mem [PALETTE_SIZE];

   logic [qcpc_pkg::QUAL_W-1:0]  quality_ff, quality_in;
   logic [qcpc_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [CW-1:0]                slots_ff, slots_in;
   logic [CW-1:0]                rd_addr_ff, rd_addr_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [qcpc_pkg::KEY_W-1:0]   key_ff;
   logic                         fixed_ff;
   logic [qcpc_pkg::KEY_W-1:0]   rd_data_ff;
   logic [AW-1:0]                cmp_idx_ff;
   logic                         res_hit_ff;
   logic [AW-1:0]                res_idx_ff;
   logic [qcpc_pkg::SLOT_W-1:0]  out_slot_ff;
   logic [qcpc_pkg::OUTC_W-1:0]  out_code_ff;

   logic [qcpc_pkg::CHAN_W-1:0]  mask;
   logic [qcpc_pkg::KEY_W-1:0]   key_new;
   logic                         issue;
   logic                         hit;
   logic [AW-1:0]                hit_idx;
   logic [LW-1:0]                lim_ext;
   logic [LW-1:0]                lim_eff;
   logic                         full;
   logic [LW-1:0]                res_slot_ext;
   logic [LW-1:0]                new_slot_ext;

   assign mask    = qcpc_pkg::channel_mask(quality_ff);
   assign key_new = {req_tdata[47:32] & mask, req_tdata[31:16] & mask,
                     req_tdata[15:0] & mask};

   assign issue   = cmd.scan && (rd_addr_ff < slots_ff);
   assign hit     = fixed_ff || (cmp_valid_ff && (rd_data_ff == key_ff));
   assign hit_idx = fixed_ff ? '0 : cmp_idx_ff;

   assign lim_ext = LW'(limit_ff);
   assign lim_eff = (lim_ext > LW'(PALETTE_SIZE)) ? LW'(PALETTE_SIZE) : lim_ext;
   assign full    = LW'(slots_ff) >= lim_eff;

   assign res_slot_ext = LW'(res_idx_ff);
   assign new_slot_ext = LW'(slots_ff);

   assign status.hit      = hit;
   assign status.miss     = !hit && !cmp_valid_ff && (rd_addr_ff >= slots_ff);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_slot_ff;
   assign rsp_tuser  = out_code_ff;

   always_comb begin
      quality_in   = quality_ff;
      limit_in     = limit_ff;
      slots_in     = slots_ff;
      rd_addr_in   = rd_addr_ff;
      cmp_valid_in = cmp_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_addr)
            qcpc_pkg::CSR_QUALITY: quality_in = csr_wdata[qcpc_pkg::QUAL_W-1:0];
            qcpc_pkg::CSR_LIMIT:   limit_in   = csr_wdata;
            default:               limit_in   = limit_ff;
         endcase
      end

      if (cmd.start) begin
         rd_addr_in   = '0;
         cmp_valid_in = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            rd_addr_in = rd_addr_ff + CW'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (!res_hit_ff && !full) begin
            slots_in = slots_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff   <= qcpc_pkg::QUALITY_RESET;
         limit_ff     <= qcpc_pkg::LIMIT_RESET;
         slots_ff     <= '0;
         rd_addr_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quality_ff   <= quality_in;
         limit_ff     <= limit_in;
         slots_ff     <= slots_in;
         rd_addr_ff   <= rd_addr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Key memory: one read per scan cycle while unread slots remain, one write when a slot is allocated.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= key_mem[rd_addr_ff[AW-1:0]];
         cmp_idx_ff <= rd_addr_ff[AW-1:0];
      end
      if (cmd.commit && !res_hit_ff && !full) begin
         key_mem[slots_ff[AW-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff   <= key_new;
         fixed_ff <= (req_tdata[15:0] == qcpc_pkg::FIXED_RED) &&
                     (req_tdata[31:16] == qcpc_pkg::FIXED_GREEN) &&
                     (req_tdata[47:32] == qcpc_pkg::FIXED_BLUE);
      end
      if (cmd.latch) begin
         res_hit_ff <= hit;
         res_idx_ff <= hit_idx;
      end
      if (cmd.commit) begin
         if (res_hit_ff) begin
            out_slot_ff <= res_slot_ext[qcpc_pkg::SLOT_W-1:0];
            out_code_ff <= qcpc_pkg::OUTCOME_HIT;
         end else if (full) begin
            out_slot_ff <= '0;
            out_code_ff <= qcpc_pkg::OUTCOME_FULL;
         end else begin
            out_slot_ff <= new_slot_ext[qcpc_pkg::SLOT_W-1:0];
            out_code_ff <= qcpc_pkg::OUTCOME_NEW;
         end
      end
   end

endmodule

FILE: sv/quantized_color_palette_cache_unit.sv
// Palette cache for 16-bit RGB colors. Each request is reduced to a key of
// the top "quality" bits per channel and searched against the keys of the
// slots allocated so far, lowest slot first; a match answers as a hit, a
// miss allocates the next slot while slots remain below palette_limit, and
// otherwise slot 0 comes back with the full status. Red 0, green 0, blue
// 0xff00 is always a hit on slot 0. Requests are handled one at a time: the
// key memory has a single read port that is scanned one entry per cycle; a
// hit ends the scan at the first matching slot, a miss reads every slot in
// use; the fixed color or an empty palette needs no read. A finished result waits
// in an output register, and the next request is taken while it does.
// Configuration writes are taken in any cycle and should only be issued while
// no request is in flight.
module quantized_color_palette_cache_unit #(
   parameter int unsigned PALETTE_SIZE = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [qcpc_pkg::KEY_W-1:0]          req_tdata,   // red, green, blue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [qcpc_pkg::SLOT_W-1:0]         rsp_tdata,   // slot_index
   output logic [qcpc_pkg::OUTC_W-1:0]         rsp_tuser,   // outcome
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_addr,
   input  logic [qcpc_pkg::LIMIT_W-1:0]        csr_wdata
);

   qcpc_pkg::cmd_type    cmd;
   qcpc_pkg::status_type status;

   assign csr_ready = 1'b1;

   qcpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qcpc_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   // A result is only loaded when the output register is empty or draining.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed over a pending response");

   // Only one request is in flight.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A committed result is presented in the following cycle.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   // The fixed color is answered as a hit on slot 0.
   a_fixed_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.latch && u_datapath.fixed_ff) |-> status.hit)
      else $error("fixed color missed");

endmodule

FILE: tb/quantized_color_palette_cache_unit_tb.sv
module quantized_color_palette_cache_unit_tb;
   import qcpc_pkg::*;

   localparam int unsigned PALETTE_DEPTH = 256;
   localparam int IDLE_LIMIT = 5000;
   localparam int HISTORY_DEPTH = 512;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } color_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic [OUTC_W-1:0] outcome;
   } palette_result_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [KEY_W-1:0]    req_tdata  = '0;   // red, green, blue
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SLOT_W-1:0]   rsp_tdata;         // slot_index
   logic [OUTC_W-1:0]   rsp_tuser;         // outcome
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic                csr_addr   = CSR_QUALITY;
   logic [LIMIT_W-1:0]  csr_wdata  = '0;

   quantized_color_palette_cache_unit #(
      .PALETTE_SIZE(PALETTE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the palette and its settings.
   logic [KEY_W-1:0]   palette_keys [PALETTE_DEPTH];
   logic [LIMIT_W-1:0] palette_fill = '0;
   logic [QUAL_W-1:0]  cfg_quality  = QUALITY_RESET;
   logic [LIMIT_W-1:0] cfg_limit    = LIMIT_RESET;

   color_type          color_requests [$];
   color_type          recent_colors [$];
   palette_result_type pending_results [$];
   int                 requests_outstanding = 0;
   int                 results_seen = 0;
   int                 fail_count = 0;
   bit                 req_taken = 1'b0;

   function automatic logic [CHAN_W-1:0] key_mask(input logic [QUAL_W-1:0] q);
      int unsigned bits;
      bits = (q == 0) ? 1 : ((q > 16) ? 16 : q);
      return ~(16'hffff >> bits);
   endfunction

   function automatic palette_result_type resolve_color(input color_type c);
      logic [CHAN_W-1:0]  m;
      logic [KEY_W-1:0]   k;
      palette_result_type r;
      int unsigned        lim;
      m = key_mask(cfg_quality);
      k = {c.red & m, c.green & m, c.blue & m};
      r.slot_index = '0;
      r.outcome    = OUTCOME_HIT;
      if (c.red == FIXED_RED && c.green == FIXED_GREEN && c.blue == FIXED_BLUE) begin
         return r;
      end
      for (int i = 0; i < palette_fill; i++) begin
         if (palette_keys[i] == k) begin
            r.slot_index = SLOT_W'(i);
            return r;
         end
      end
      lim = (cfg_limit > PALETTE_DEPTH) ? PALETTE_DEPTH : cfg_limit;
      if (palette_fill >= lim) begin
         r.outcome = OUTCOME_FULL;
         return r;
      end
      palette_keys[palette_fill] = k;
      r.slot_index = palette_fill[SLOT_W-1:0];
      r.outcome    = OUTCOME_NEW;
      palette_fill = palette_fill + 1'b1;
      return r;
   endfunction

   // Picks the fixed color, a one-bit neighbour of it, a fresh color, or an
   // earlier one scrambled below the key mask, so that lookups hit stored slots.
   function automatic color_type pick_color(input int fresh_pct);
      color_type         c;
      logic [CHAN_W-1:0] m;
      int                roll;
      roll = $urandom_range(0, 99);
      m    = key_mask(cfg_quality);
      if (roll < 5) begin
         c.red   = FIXED_RED;
         c.green = FIXED_GREEN;
         c.blue  = FIXED_BLUE;
      end else if (roll < 8) begin
         c = {FIXED_BLUE, FIXED_GREEN, FIXED_RED} ^ (48'd1 << $urandom_range(0, 47));
      end else if (roll < 8 + fresh_pct || recent_colors.size() == 0) begin
         c = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else begin
         c = recent_colors[$urandom_range(0, recent_colors.size() - 1)];
         c.red   = c.red   ^ (16'($urandom) & ~m);
         c.green = c.green ^ (16'($urandom) & ~m);
         c.blue  = c.blue  ^ (16'($urandom) & ~m);
      end
      if (recent_colors.size() < HISTORY_DEPTH) begin
         recent_colors.push_back(c);
      end else begin
         recent_colors[$urandom_range(0, HISTORY_DEPTH - 1)] = c;
      end
      return c;
   endfunction

   task automatic queue_color(input color_type c);
      color_requests.push_back(c);
      requests_outstanding++;
   endtask

   task automatic queue_rgb(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
      color_type c;
      c.red   = r;
      c.green = g;
      c.blue  = b;
      recent_colors.push_back(c);
      queue_color(c);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (requests_outstanding != 0 || pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic addr, input logic [LIMIT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (addr == CSR_QUALITY) begin
         cfg_quality = data[QUAL_W-1:0];
      end else begin
         cfg_limit = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int count, input int fresh_pct);
      repeat (count) queue_color(pick_color(fresh_pct));
      wait_idle();
   endtask

   // The upper write bits are ignored for quality, so they carry noise.
   task automatic set_quality(input int q);
      csr_write(CSR_QUALITY, {4'($urandom), 5'(q)});
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0 || color_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tdata  <= color_requests.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver: a random readiness pattern is redrawn periodically, and one long
   // hold-off lets the block back up into its request side.
   int  ready_mode     = 0;
   int  mode_cycles    = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 1'b0;
   always @(negedge clock) begin
      if (!long_hold_done && results_seen >= 150) begin
         long_hold_left = 600;
         long_hold_done = 1'b1;
      end
      if (++mode_cycles == 50) begin
         mode_cycles = 0;
         ready_mode  = $urandom_range(0, 3);
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      palette_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            pending_results.push_back(resolve_color(color_type'(req_tdata)));
            requests_outstanding--;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result with no request pending: slot_index %0d, outcome %0d",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.slot_index) begin
                  $error("slot_index mismatch: expected %0d, got %0d",
                         want.slot_index, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.outcome) begin
                  $error("outcome mismatch: expected %0d, got %0d", want.outcome, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("** quantized_color_palette_cache_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: quality 6, limit 256, empty palette.
      queue_rgb(16'h0000, 16'h0000, 16'hff00);   // fixed color on an empty palette
      queue_rgb(16'h0000, 16'h0000, 16'h0000);
      queue_rgb(16'hffff, 16'hffff, 16'hffff);
      queue_rgb(16'h0000, 16'h0000, 16'h03ff);   // masks onto the all-zero key
      queue_rgb(16'h0000, 16'h0000, 16'hff01);   // next to the fixed color, allocates
      queue_rgb(16'h0000, 16'h0000, 16'hff00);
      queue_rgb(16'h0000, 16'h0000, 16'hfc00);
      queue_rgb(16'h0001, 16'h0000, 16'hff00);
      queue_rgb(16'hffff, 16'h0000, 16'h0000);
      queue_rgb(16'h0000, 16'hffff, 16'h0000);
      queue_rgb(16'h0000, 16'h0000, 16'hffff);
      queue_rgb(16'hfc00, 16'hfc00, 16'hfc00);
      queue_rgb(16'h8000, 16'h0400, 16'h0001);
      queue_rgb(16'h7fff, 16'hfbff, 16'h5555);
      wait_idle();

      // A limit of zero: every miss is full, stored slots still hit.
      csr_write(CSR_LIMIT, 9'd0);
      run_phase(20, 40);

      // Quality 0 acts as 1.
      set_quality(0);
      csr_write(CSR_LIMIT, 9'd40);
      run_phase(200, 30);

      // Quality above 16 acts as 16.
      set_quality(31);
      csr_write(CSR_LIMIT, 9'd120);
      run_phase(250, 35);

      // Limit below the slots in use.
      set_quality(1);
      csr_write(CSR_LIMIT, 9'd1);
      run_phase(100, 40);

      set_quality(10);
      csr_write(CSR_LIMIT, 9'd256);
      run_phase(350, 60);

      // Limit above the store size is capped.
      set_quality(16);
      csr_write(CSR_LIMIT, 9'd300);
      run_phase(200, 30);

      set_quality(17);
      csr_write(CSR_LIMIT, 9'd511);
      run_phase(150, 30);

      set_quality(6);
      csr_write(CSR_LIMIT, 9'd256);
      run_phase(120, 30);

      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("** quantized_color_palette_cache_unit: PASSED **");
      end else begin
         $display("** quantized_color_palette_cache_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/qcpc_pkg.sv
sv/qcpc_ctrl.sv
sv/qcpc_datapath.sv
sv/quantized_color_palette_cache_unit.sv
tb/quantized_color_palette_cache_unit_tb.sv
